// ===== src/ffba_pkg.sv =====
// Shared types and constants of the first-fit block heap allocator.
// Depends on nothing; the controller, datapath and top level import it.
package ffba_pkg;

	// Operation codes
	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_FREE  = 3'd1;
	localparam logic [2:0] OP_LIST  = 3'd2;
	localparam logic [2:0] OP_FILL  = 3'd3;
	localparam logic [2:0] OP_BYTE  = 3'd4;
	localparam logic [2:0] OP_HDR   = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_TOOBIG   = 2'd3;

	// Kind of result to build in the output register
	localparam logic [2:0] RES_OK       = 3'd0;
	localparam logic [2:0] RES_NOSPACE  = 3'd1;
	localparam logic [2:0] RES_NOTFOUND = 3'd2;
	localparam logic [2:0] RES_TOOBIG   = 3'd3;
	localparam logic [2:0] RES_ALLOC    = 3'd4;
	localparam logic [2:0] RES_LIST     = 3'd5;
	localparam logic [2:0] RES_BYTE     = 3'd6;
	localparam logic [2:0] RES_HDR      = 3'd7;

	// Second header byte of the initial free block at reset
	localparam logic [7:0] HDR_INIT  = 8'd254;
	localparam int         LIST_MAX  = 64;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] block_id;
		logic [7:0] amount;
		logic [7:0] fill_char;
		logic [7:0] byte_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] new_block_id;
		logic [7:0] data_byte;
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] list_size;
		logic       list_allocated;
		logic [6:0] list_start;
		logic [7:0] list_end;
		logic       last;
	} rsp_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       rd_blk;
		logic       step;
		logic       wr_id;
		logic       wr_hdr;
		logic       set_split;
		logic       set_rd;
		logic       set_fill;
		logic       reduce;
		logic       wr_split;
		logic       wr_fill;
		logic       rd_addr;
		logic       res_load;
		logic [2:0] res_kind;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       walk_end;
		logic       match;
		logic       too_big;
		logic       do_split;
		logic       addr_hi;
		logic       fill_done;
		logic       list_last;
		logic       out_busy;
	} sts_t;

endpackage

// ===== src/ffba_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then read with registered data held between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule

// ===== src/ffba_datapath.sv =====
// Datapath of the allocator: heap RAM with valid bits, walk pointer, address
// unit, block counter and result register. Uses ffba_pkg and ffba_ram.
module ffba_datapath
	import ffba_pkg::*;
#(
	parameter int HEAP_SIZE = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic rsp_stall,
	output logic rsp_valid,
	output rsp_t rsp
);
	localparam int AW  = $clog2(HEAP_SIZE);
	localparam int PW  = $clog2(HEAP_SIZE + 128);
	localparam int AQW = $clog2(HEAP_SIZE + 256);
	// Second header byte of the single free block that spans the heap
	localparam logic [7:0] HDR_RST = 8'((HEAP_SIZE - 1) * 2);

	logic [2:0]     op_q;
	logic [7:0]     id_q, amt_q, ch_q, idx_q;
	logic [PW-1:0]  p_q;
	logic [5:0]     k_q;
	logic [7:0]     cnt_q;
	logic [AQW-1:0] addr_q;
	logic [7:0]     fcnt_q;
	logic [HEAP_SIZE-1:0] vld_q;
	logic           rva_q, rvb_q, ra1_q, rb1_q;
	logic           out_valid_q;
	rsp_t           out_q, out_d;

	logic [AW-1:0]  pa, raddr_a, raddr_b, waddr;
	logic           we, re;
	logic [7:0]     wdata, ram_a, ram_b, b0, b1, sz;
	logic [8:0]     need;
	logic [7:0]     split_hdr, rem_hdr;
	logic [PW-1:0]  p_next;

	assign pa   = p_q[AW-1:0];
	assign need = {1'b0, amt_q} + 9'd2;
	assign sz   = {1'b0, b1[7:1]} + 8'd1;
	assign p_next = p_q + PW'(sz);
	assign split_hdr = {amt_q[6:0] + 7'd1, 1'b1};
	assign rem_hdr   = {8'(9'(sz) - need - 9'd1)} << 1;

	// Heap storage
	assign re      = cmd.rd_blk | cmd.rd_addr;
	assign raddr_a = cmd.rd_blk ? pa : addr_q[AW-1:0];
	assign raddr_b = pa + AW'(1);

	always_comb begin
		we    = 1'b1;
		waddr = pa;
		wdata = 8'(cnt_q + 8'd1);
		if (cmd.wr_hdr) begin
			waddr = pa + AW'(1);
			if (op_q == OP_ALLOC) begin
				wdata = sts.do_split ? split_hdr : (b1 | 8'd1);
			end else begin
				wdata = b1 & 8'hFE;
			end
		end else if (cmd.wr_split) begin
			waddr = addr_q[AW-1:0];
			wdata = rem_hdr;
		end else if (cmd.wr_fill) begin
			waddr = addr_q[AW-1:0];
			wdata = ch_q;
		end else if (!cmd.wr_id) begin
			we = 1'b0;
		end
	end

	ffba_ram #(.WIDTH(8), .DEPTH(HEAP_SIZE)) u_heap (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	// Unwritten bytes read as their reset value
	assign b0 = rva_q ? ram_a : (ra1_q ? HDR_RST : 8'd0);
	assign b1 = rvb_q ? ram_b : (rb1_q ? HDR_RST : 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rva_q <= vld_q[raddr_a];
			rvb_q <= vld_q[raddr_b];
			ra1_q <= raddr_a == AW'(1);
			rb1_q <= raddr_b == AW'(1);
		end
	end

	// Latch request fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.opcode;
			id_q  <= req.block_id;
			amt_q <= req.amount;
			ch_q  <= req.fill_char;
			idx_q <= req.byte_index;
		end
	end

	// Walk pointer, list count and block counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= '0;
			k_q   <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				p_q <= '0;
				k_q <= '0;
			end else if (cmd.step) begin
				p_q <= p_next;
				k_q <= k_q + 6'd1;
			end
			if (cmd.wr_id) begin
				cnt_q <= cnt_q + 8'd1;
			end
		end
	end

	// Address unit: load, wrap by subtraction, advance for fill
	always_ff @(posedge clk) begin
		if (cmd.set_split) begin
			addr_q <= AQW'(p_q) + AQW'(need) + AQW'(1);
		end else if (cmd.set_rd) begin
			addr_q <= AQW'(p_q) + AQW'(idx_q) + AQW'(2);
		end else if (cmd.set_fill) begin
			addr_q <= AQW'(p_q) + AQW'(2);
		end else if (cmd.reduce) begin
			addr_q <= addr_q - AQW'(HEAP_SIZE);
		end else if (cmd.wr_fill) begin
			addr_q <= (addr_q == AQW'(HEAP_SIZE - 1)) ? '0 : addr_q + AQW'(1);
		end
		if (cmd.set_fill) begin
			fcnt_q <= amt_q;
		end else if (cmd.wr_fill) begin
			fcnt_q <= fcnt_q - 8'd1;
		end
	end

	// Status to controller
	always_comb begin
		sts.op        = op_q;
		sts.walk_end  = p_q >= PW'(HEAP_SIZE - 2);
		sts.match     = (op_q == OP_ALLOC) ? (!b1[0] && {1'b0, sz} >= need)
		                                   : (b0 == id_q);
		sts.too_big   = {1'b0, sz} < need;
		sts.do_split  = {1'b0, sz} >= need + 9'd3;
		sts.addr_hi   = addr_q >= AQW'(HEAP_SIZE);
		sts.fill_done = fcnt_q == 8'd0;
		sts.list_last = (k_q == 6'(LIST_MAX - 1)) || (p_next >= PW'(HEAP_SIZE - 2));
		sts.out_busy  = out_valid_q;
	end

	// Build the result beat
	always_comb begin
		out_d      = '0;
		out_d.last = 1'b1;
		case (cmd.res_kind)
			RES_NOSPACE:  out_d.status = ST_NOSPACE;
			RES_NOTFOUND: out_d.status = ST_NOTFOUND;
			RES_TOOBIG:   out_d.status = ST_TOOBIG;
			RES_ALLOC:    out_d.new_block_id = cnt_q;
			RES_BYTE:     out_d.data_byte = b0;
			RES_HDR: begin
				out_d.header_first  = b0;
				out_d.header_second = b1;
			end
			RES_LIST: begin
				out_d.list_size      = sz;
				out_d.list_allocated = b1[0];
				out_d.list_start     = 7'(p_q);
				out_d.list_end       = 8'(p_q + PW'(sz) - PW'(1));
				out_d.last           = sts.list_last;
			end
			default: out_d.status = ST_OK;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Checks
	a_blk_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_blk |-> p_q < PW'(HEAP_SIZE - 2))
		else $error("block read outside heap");
	a_addr_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_split || cmd.wr_fill || cmd.rd_addr) |-> addr_q < AQW'(HEAP_SIZE))
		else $error("heap address not wrapped");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !out_valid_q)
		else $error("result overwritten before taken");
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_fill |-> fcnt_q != 8'd0)
		else $error("fill past requested count");
endmodule

// ===== src/ffba_ctrl.sv =====
// Controller of the allocator: sequences walk, writes and results.
// Uses ffba_pkg; drives the datapath through cmd_t and reads sts_t.
module ffba_ctrl
	import ffba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_EV    = 4'd2;
	localparam logic [3:0] S_WHDR  = 4'd3;
	localparam logic [3:0] S_SRED  = 4'd4;
	localparam logic [3:0] S_FILL  = 4'd5;
	localparam logic [3:0] S_RRED  = 4'd6;
	localparam logic [3:0] S_RWAIT = 4'd7;
	localparam logic [3:0] S_WAIT  = 4'd8;
	localparam logic [3:0] S_LWAIT = 4'd9;

	logic [3:0] state_q, state_d;

	assign req_stall = state_q != S_IDLE;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				if (!(sts.op inside {[OP_ALLOC:OP_HDR]})) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_OK;
					state_d      = S_WAIT;
				end else if (sts.walk_end) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = (sts.op == OP_ALLOC) ? RES_NOSPACE : RES_NOTFOUND;
					state_d      = S_WAIT;
				end else begin
					cmd.rd_blk = 1'b1;
					state_d    = S_EV;
				end
			end
			S_EV: begin
				if (sts.op == OP_LIST) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_LIST;
					state_d      = S_LWAIT;
				end else if (!sts.match) begin
					cmd.step = 1'b1;
					state_d  = S_RD;
				end else begin
					case (sts.op)
						OP_ALLOC: begin
							cmd.wr_id = 1'b1;
							state_d   = S_WHDR;
						end
						OP_FREE: begin
							cmd.wr_hdr   = 1'b1;
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_OK;
							state_d      = S_WAIT;
						end
						OP_FILL: begin
							if (sts.too_big) begin
								cmd.res_load = 1'b1;
								cmd.res_kind = RES_TOOBIG;
								state_d      = S_WAIT;
							end else begin
								cmd.set_fill = 1'b1;
								state_d      = S_FILL;
							end
						end
						OP_BYTE: begin
							cmd.set_rd = 1'b1;
							state_d    = S_RRED;
						end
						default: begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_HDR;
							state_d      = S_WAIT;
						end
					endcase
				end
			end
			S_WHDR: begin
				cmd.wr_hdr = 1'b1;
				if (sts.do_split) begin
					cmd.set_split = 1'b1;
					state_d       = S_SRED;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ALLOC;
					state_d      = S_WAIT;
				end
			end
			S_SRED: begin
				if (sts.addr_hi) begin
					cmd.reduce = 1'b1;
				end else begin
					cmd.wr_split = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ALLOC;
					state_d      = S_WAIT;
				end
			end
			S_FILL: begin
				if (sts.fill_done) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_OK;
					state_d      = S_WAIT;
				end else begin
					cmd.wr_fill = 1'b1;
				end
			end
			S_RRED: begin
				if (sts.addr_hi) begin
					cmd.reduce = 1'b1;
				end else begin
					cmd.rd_addr = 1'b1;
					state_d     = S_RWAIT;
				end
			end
			S_RWAIT: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = RES_BYTE;
				state_d      = S_WAIT;
			end
			S_WAIT: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			S_LWAIT: begin
				if (!sts.out_busy) begin
					if (sts.list_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Checks
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE)
		else $error("request taken while busy");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.wr_id, cmd.wr_split, cmd.wr_fill, cmd.wr_hdr}) <= 1)
		else $error("two heap writes at once");
	a_load_then_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_RD)
		else $error("load did not start a walk");
endmodule

// ===== src/first_fit_block_heap_allocator_core.sv =====
// Top level of the first-fit block heap allocator: controller plus datapath.
// Uses ffba_pkg, ffba_ctrl, ffba_datapath.
//
// Manages a HEAP_SIZE-byte heap as an implicit list of blocks with two-byte
// headers. One request is handled at a time; req_stall is high from the cycle
// after acceptance until the cycle after the last result beat has been taken.
// A request with a defined opcode walks the block list from address zero,
// a registered RAM read and then an evaluate step per block, until a match
// or the end-of-heap check. On a match, allocate writes the block id and
// header, and the split header if the block splits (reducing a wrapped split
// address first); fill writes the requested bytes; read byte reduces the
// offset address once per heap-size wrap, then reads the byte. Each result
// beat waits out downstream stall, then the controller goes idle for the next
// request. A list returns one beat per block, at most 64. No clearing pass is
// needed after reset: per-byte valid bits make unwritten bytes read as reset.
module first_fit_block_heap_allocator_core
	import ffba_pkg::*;
#(
	parameter int HEAP_SIZE = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);
	cmd_t cmd;
	sts_t sts;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffba_datapath #(.HEAP_SIZE(HEAP_SIZE)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);
endmodule
